// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

   localparam int unsigned RUN_MAX   = 6;
   localparam int unsigned RUN_CNT_W = 3;

   localparam logic [15:0] CAP_RESET = 16'd256;

   // parser modes
   localparam logic [2:0] MODE_QUOTE    = 3'd0;
   localparam logic [2:0] MODE_BODY     = 3'd1;
   localparam logic [2:0] MODE_ESC      = 3'd2;
   localparam logic [2:0] MODE_HEX      = 3'd3;
   localparam logic [2:0] MODE_HIGH     = 3'd4;
   localparam logic [2:0] MODE_HIGH_ESC = 3'd5;
   localparam logic [2:0] MODE_SKIP     = 3'd6;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] hex_accum;
      logic [2:0]  hex_count;
      logic        hex_bad;
      logic [15:0] pending_high;
      logic        pending_valid;
      logic [15:0] bytes_written;
      logic        token_bad;
   } state_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [RUN_CNT_W-1:0]    count;
      logic                    byte_valid;
      logic                    token_end;
      logic                    token_ok;
   } run_type;

endpackage

// ===== rtl/jsu_decode.sv =====
module jsu_decode (
   input  jsu_pkg::state_type st,
   input  logic [7:0]         in_byte,
   input  logic               token_last,
   input  logic [15:0]        capacity,
   output jsu_pkg::state_type nxt,
   output jsu_pkg::run_type   run,
   output logic               run_valid
);
   import jsu_pkg::*;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;

   logic [3:0]  hex_digit;
   logic        hex_ok;
   logic [15:0] acc_n;
   logic [2:0]  cnt_n;
   logic        bad_n;
   logic        acc_low;
   logic        acc_high;
   logic [7:0]  esc_byte;
   logic [20:0] joined_cp;

   state_type   nst;
   logic        proc;
   logic        do_body;
   logic        do_esc;
   logic        flush_a;
   logic        b_valid;
   logic        b_raw;
   logic [7:0]  b_byte;
   logic [20:0] b_cp;
   logic        new_pend;
   logic        bad_all;

   logic [3:0][7:0] enc_bytes;
   logic [2:0]      enc_len;
   logic [3:0][7:0] b_bytes;
   logic [2:0]      b_len;
   logic [2:0][7:0] a_bytes;
   logic [RUN_MAX-1:0][7:0] cand;
   logic [2:0]      k;
   logic [15:0]     avail;
   logic [2:0]      n;

   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_digit = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_digit = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_digit = 4'(in_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign bad_n    = st.hex_bad | ~hex_ok;
   assign acc_n    = hex_ok ? {st.hex_accum[11:0], hex_digit} : st.hex_accum;
   assign cnt_n    = st.hex_count + 3'd1;
   assign acc_low  = acc_n >= 16'hDC00 && acc_n <= 16'hDFFF;
   assign acc_high = acc_n >= 16'hD800 && acc_n <= 16'hDBFF;
   // surrogate pair: both offsets fit in ten bits
   assign joined_cp = 21'h10000 + {1'b0, st.pending_high[9:0], acc_n[9:0]};

   always_comb begin
      case (in_byte)
         8'h62:   esc_byte = 8'h08;
         8'h66:   esc_byte = 8'h0C;
         8'h6E:   esc_byte = 8'h0A;
         8'h72:   esc_byte = 8'h0D;
         8'h74:   esc_byte = 8'h09;
         default: esc_byte = in_byte;
      endcase
   end

   always_comb begin
      nst      = st;
      do_body  = 1'b0;
      do_esc   = 1'b0;
      flush_a  = 1'b0;
      b_valid  = 1'b0;
      b_raw    = 1'b0;
      b_byte   = in_byte;
      b_cp     = '0;
      new_pend = 1'b0;
      proc     = ~token_last ||
                 (st.mode >= MODE_BODY && st.mode <= MODE_HIGH_ESC && in_byte != CH_QUOTE);

      if (proc) begin
         unique case (st.mode)
            MODE_QUOTE: begin
               if (in_byte == CH_QUOTE) begin
                  nst.mode = MODE_BODY;
               end else begin
                  nst.token_bad = 1'b1;
                  nst.mode      = MODE_SKIP;
               end
            end
            MODE_BODY: do_body = 1'b1;
            MODE_ESC:  do_esc = 1'b1;
            MODE_HEX: begin
               nst.hex_accum = acc_n;
               nst.hex_count = cnt_n;
               nst.hex_bad   = bad_n;
               if (cnt_n >= 3'd4) begin
                  nst.mode = MODE_BODY;
                  if (st.pending_valid && !bad_n && acc_low) begin
                     b_valid           = 1'b1;
                     b_cp              = joined_cp;
                     nst.pending_valid = 1'b0;
                  end else begin
                     if (st.pending_valid) begin
                        flush_a           = 1'b1;
                        nst.pending_valid = 1'b0;
                     end
                     if (!bad_n) begin
                        if (acc_high) begin
                           nst.pending_high  = acc_n;
                           nst.pending_valid = 1'b1;
                           nst.mode          = MODE_HIGH;
                           new_pend          = 1'b1;
                        end else begin
                           b_valid = 1'b1;
                           b_cp    = {5'd0, acc_n};
                        end
                     end
                  end
               end
            end
            MODE_HIGH: begin
               if (in_byte == CH_BSL) begin
                  nst.mode = MODE_HIGH_ESC;
               end else begin
                  flush_a           = 1'b1;
                  nst.pending_valid = 1'b0;
                  do_body           = 1'b1;
               end
            end
            MODE_HIGH_ESC: begin
               // \u keeps the held surrogate, anything else releases it first
               if (in_byte != CH_U) begin
                  flush_a           = 1'b1;
                  nst.pending_valid = 1'b0;
               end
               do_esc = 1'b1;
            end
            default: ;
         endcase
      end

      if (do_body) begin
         if (in_byte == CH_BSL) begin
            nst.mode = MODE_ESC;
         end else begin
            b_valid  = 1'b1;
            b_raw    = 1'b1;
            b_byte   = in_byte;
            nst.mode = MODE_BODY;
         end
      end
      if (do_esc) begin
         if (in_byte == CH_U) begin
            nst.mode      = MODE_HEX;
            nst.hex_accum = '0;
            nst.hex_count = '0;
            nst.hex_bad   = 1'b0;
         end else begin
            b_valid  = 1'b1;
            b_raw    = 1'b1;
            b_byte   = esc_byte;
            nst.mode = MODE_BODY;
         end
      end

      bad_all = nst.token_bad | (st.mode == MODE_QUOTE);

      if (token_last) begin
         // a surrogate still held at the end goes out alone
         if (nst.mode <= MODE_HIGH_ESC && nst.pending_valid) begin
            if (new_pend) begin
               b_valid = 1'b1;
               b_cp    = {5'd0, nst.pending_high};
            end else begin
               flush_a = 1'b1;
            end
         end
         nst.mode          = MODE_QUOTE;
         nst.hex_accum     = '0;
         nst.hex_count     = '0;
         nst.hex_bad       = 1'b0;
         nst.pending_high  = '0;
         nst.pending_valid = 1'b0;
         nst.token_bad     = 1'b0;
      end
   end

   // utf-8 encoding of the second code point
   always_comb begin
      enc_bytes = '0;
      if (b_cp <= 21'h7F) begin
         enc_len      = 3'd1;
         enc_bytes[0] = b_cp[7:0];
      end else if (b_cp <= 21'h7FF) begin
         enc_len      = 3'd2;
         enc_bytes[0] = 8'hC0 | {3'd0, b_cp[10:6]};
         enc_bytes[1] = 8'h80 | {2'd0, b_cp[5:0]};
      end else if (b_cp <= 21'hFFFF) begin
         enc_len      = 3'd3;
         enc_bytes[0] = 8'hE0 | {4'd0, b_cp[15:12]};
         enc_bytes[1] = 8'h80 | {2'd0, b_cp[11:6]};
         enc_bytes[2] = 8'h80 | {2'd0, b_cp[5:0]};
      end else begin
         enc_len      = 3'd4;
         enc_bytes[0] = 8'hF0 | {5'd0, b_cp[20:18]};
         enc_bytes[1] = 8'h80 | {2'd0, b_cp[17:12]};
         enc_bytes[2] = 8'h80 | {2'd0, b_cp[11:6]};
         enc_bytes[3] = 8'h80 | {2'd0, b_cp[5:0]};
      end
   end

   // a held high surrogate always takes three bytes
   assign a_bytes[0] = 8'hE0 | {4'd0, st.pending_high[15:12]};
   assign a_bytes[1] = 8'h80 | {2'd0, st.pending_high[11:6]};
   assign a_bytes[2] = 8'h80 | {2'd0, st.pending_high[5:0]};

   always_comb begin
      if (b_raw) begin
         b_bytes    = '0;
         b_bytes[0] = b_byte;
         b_len      = b_valid ? 3'd1 : 3'd0;
      end else begin
         b_bytes = enc_bytes;
         b_len   = b_valid ? enc_len : 3'd0;
      end
      if (flush_a) begin
         cand[0] = a_bytes[0];
         cand[1] = a_bytes[1];
         cand[2] = a_bytes[2];
         cand[3] = b_bytes[0];
         cand[4] = b_bytes[1];
         cand[5] = b_bytes[2];
         k       = 3'd3 + b_len;
      end else begin
         cand[0] = b_bytes[0];
         cand[1] = b_bytes[1];
         cand[2] = b_bytes[2];
         cand[3] = b_bytes[3];
         cand[4] = 8'd0;
         cand[5] = 8'd0;
         k       = b_len;
      end
   end

   // room left in the buffer, one entry kept for the terminator
   assign avail = (capacity > st.bytes_written + 16'd1) ?
                  capacity - st.bytes_written - 16'd1 : 16'd0;
   assign n     = (avail < {13'd0, k}) ? avail[2:0] : k;

   always_comb begin
      nxt = nst;
      if (!token_last) begin
         nxt.bytes_written = st.bytes_written + {13'd0, n};
      end else begin
         nxt.bytes_written = '0;
      end
      run.bytes      = cand;
      run.byte_valid = n != 3'd0;
      run.count      = (token_last && n == 3'd0) ? 3'd1 : n;
      run.token_end  = token_last;
      run.token_ok   = token_last & ~bad_all & (capacity != 16'd0);
      run_valid      = run.count != 3'd0;
   end

endmodule

// ===== rtl/json_string_unescape_to_utf8.sv =====
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_in_byte, req_token_last
// rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_byte_valid, rsp_run_last,
//                                           rsp_token_end, rsp_token_ok
// csr      in         csr_valid/csr_ready   csr_output_capacity
//
// one input word is decoded in the cycle it is taken; its 0 to 6 result words
// go out from a run register at one word per cycle while rsp is not stalled.
// the next input word is taken in the cycle the last result of the run leaves.
// reset is synchronous; it sets the parser to wait for an opening quote and
// the capacity to 256. a stalled rsp word holds, and req is stalled while a
// run is held, until its last word leaves.
module json_string_unescape_to_utf8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_token_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_run_last,
   output logic        rsp_token_end,
   output logic        rsp_token_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_output_capacity
);
   import jsu_pkg::*;

   logic [15:0]          cap_ff, cap_in;
   state_type            st_ff, st_in;
   run_type              run_ff, run_in;
   logic                 run_valid_ff, run_valid_in;
   logic [RUN_CNT_W-1:0] idx_ff, idx_in;

   state_type            dec_st;
   run_type              dec_run;
   logic                 dec_run_valid;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 last_idx;
   logic                 drain;

   jsu_decode u_decode (
      .st         (st_ff),
      .in_byte    (req_in_byte),
      .token_last (req_token_last),
      .capacity   (cap_ff),
      .nxt        (dec_st),
      .run        (dec_run),
      .run_valid  (dec_run_valid)
   );

   assign csr_ready = 1'b1;
   assign cap_in    = csr_valid ? csr_output_capacity : cap_ff;

   assign last_idx  = idx_ff == run_ff.count - 3'd1;
   assign rsp_fire  = run_valid_ff & ~rsp_stall;
   assign drain     = rsp_fire & last_idx;
   assign req_stall = run_valid_ff & ~drain;
   assign req_fire  = req_valid & ~req_stall;

   assign rsp_valid      = run_valid_ff;
   assign rsp_out_byte   = run_ff.byte_valid ? run_ff.bytes[idx_ff] : 8'd0;
   assign rsp_byte_valid = run_ff.byte_valid;
   assign rsp_run_last   = last_idx;
   assign rsp_token_end  = run_ff.token_end & last_idx;
   assign rsp_token_ok   = run_ff.token_ok & last_idx;

   always_comb begin
      st_in        = st_ff;
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      idx_in       = idx_ff;
      if (req_fire) begin
         st_in        = dec_st;
         run_in       = dec_run;
         run_valid_in = dec_run_valid;
         idx_in       = '0;
      end else if (rsp_fire) begin
         if (last_idx) begin
            run_valid_in = 1'b0;
         end
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         st_ff        <= '{mode: MODE_QUOTE, default: '0};
         run_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cap_ff       <= cap_in;
         st_ff        <= st_in;
         run_valid_ff <= run_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // run payload needs no reset
   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

endmodule
